// ===== rtl/upd_pkg.sv =====
// Shared types, character constants and helper functions for the URL percent decoder.
// Used by every module of the decoder; depends on nothing else.
package upd_pkg;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Escape phase codes.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	// Default number of entries in the queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_string;
	} out_item_t;

	// One decoded input byte: one or two results, the second always carries a byte.
	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic       v0;
		logic [7:0] b1;
		logic       eos;
	} cmd_t;

	function automatic logic hex_valid(input logic [7:0] c);
		logic r;
		r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
			((c >= 8'h41) && (c <= 8'h46));
		return r;
	endfunction

	// Nibble of a hex digit; zero for anything else.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] r;
		r = 4'd0;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			r = c[3:0];
		end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
			r = c[3:0] + 4'd9;
		end
		return r;
	endfunction

endpackage

// ===== rtl/upd_front.sv =====
// Front end of the URL percent decoder: tracks the escape phase and classifies each byte.
// Depends on upd_pkg for the item types, character codes and hex helpers.
module upd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  upd_pkg::in_item_t item,
	output logic              cmd_push,
	output upd_pkg::cmd_t     cmd
);

	logic [1:0] phase_q;
	logic [7:0] held_q;

	logic [1:0] nphase;
	logic [7:0] nheld;
	logic [1:0] cnt;
	logic [7:0] s0;
	logic [7:0] s1;
	logic       v0;

	logic [7:0] c;
	logic       is_hex;
	logic       p_emit;
	logic       p_pct;
	logic [7:0] p_byte;

	assign c      = item.in_byte;
	assign is_hex = upd_pkg::hex_valid(c);
	assign p_pct  = (c == upd_pkg::CHAR_PCT);
	assign p_emit = !p_pct;
	assign p_byte = (c == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : c;

	always_comb begin
		nphase = upd_pkg::PH_IDLE;
		nheld  = held_q;
		cnt    = 2'd0;
		s0     = 8'h00;
		s1     = 8'h00;
		v0     = 1'b1;
		case (phase_q)
			upd_pkg::PH_PCT: begin
				if (is_hex) begin
					nphase = upd_pkg::PH_DIGIT;
					nheld  = c;
				end else begin
					nphase = p_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
					if (p_emit) begin
						s0  = p_byte;
						cnt = 2'd1;
					end
				end
			end
			upd_pkg::PH_DIGIT: begin
				nheld = 8'h00;
				if (is_hex) begin
					s0  = {upd_pkg::hex_value(held_q), upd_pkg::hex_value(c)};
					cnt = 2'd1;
				end else begin
					s0     = held_q;
					nphase = p_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
					if (p_emit) begin
						s1  = p_byte;
						cnt = 2'd2;
					end else begin
						cnt = 2'd1;
					end
				end
			end
			default: begin
				nphase = p_pct ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
				if (p_emit) begin
					s0  = p_byte;
					cnt = 2'd1;
				end
			end
		endcase
		if (item.is_last) begin
			// A half-finished escape gives out its digit; a bare percent sign is dropped.
			if (nphase == upd_pkg::PH_DIGIT) begin
				if (cnt == 2'd0) begin
					s0  = nheld;
					cnt = 2'd1;
				end else begin
					s1  = nheld;
					cnt = 2'd2;
				end
			end
			nphase = upd_pkg::PH_IDLE;
			nheld  = 8'h00;
			if (cnt == 2'd0) begin
				// No byte to give: a lone end marker.
				s0  = 8'h00;
				v0  = 1'b0;
				cnt = 2'd1;
			end
		end
	end

	assign cmd_push = accept && (cnt != 2'd0);
	assign cmd.two  = (cnt == 2'd2);
	assign cmd.b0   = s0;
	assign cmd.v0   = v0;
	assign cmd.b1   = s1;
	assign cmd.eos  = item.is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
			held_q  <= 8'h00;
		end else if (accept) begin
			phase_q <= nphase;
			held_q  <= nheld;
		end
	end

endmodule

// ===== rtl/upd_queue.sv =====
// Short first-in first-out queue of decode commands between the front and back ends.
// Depends on upd_pkg for the command type.
module upd_queue #(
	parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  upd_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output logic          not_empty,
	output upd_pkg::cmd_t rd_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	upd_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/upd_back.sv =====
// Back end of the URL percent decoder: unpacks each command into one or two results.
// Depends on upd_pkg for the command and result types.
module upd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_avail,
	input  upd_pkg::cmd_t      cmd,
	output logic               cmd_take,
	input  logic               pop,
	output logic               empty,
	output upd_pkg::out_item_t rdata
);

	upd_pkg::out_item_t out_q;
	logic               valid_q;
	logic               sec_q;
	logic [7:0]         sec_byte_q;
	logic               sec_eos_q;
	logic               free;

	// The output register can be loaded when it is empty or its result leaves now.
	assign free     = !valid_q || pop;
	assign cmd_take = free && !sec_q && cmd_avail;
	assign empty    = !valid_q;
	assign rdata    = out_q;

	always_ff @(posedge clk) begin
		if (free) begin
			if (sec_q) begin
				out_q.out_byte      <= sec_byte_q;
				out_q.byte_valid    <= 1'b1;
				out_q.end_of_string <= sec_eos_q;
			end else if (cmd_avail) begin
				out_q.out_byte      <= cmd.b0;
				out_q.byte_valid    <= cmd.v0;
				out_q.end_of_string <= cmd.eos && !cmd.two;
				sec_byte_q          <= cmd.b1;
				sec_eos_q           <= cmd.eos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sec_q   <= 1'b0;
		end else if (free) begin
			if (sec_q) begin
				valid_q <= 1'b1;
				sec_q   <= 1'b0;
			end else if (cmd_avail) begin
				valid_q <= 1'b1;
				sec_q   <= cmd.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/url_percent_decoder_unit.sv =====
// Streaming URL percent decoder: one raw byte in per cycle unless full, decoded results out as a queue.
// A result passes through the queue into the back end's output register before it shows
// on rdata; a second result from the same byte follows it. Throughput: one byte per cycle
// in while not full, one result per cycle out while popped, set by the single output register.
// Reset (arst_n low, asynchronous) clears the escape phase, the queue and the output stage.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
module url_percent_decoder_unit #(
	parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  upd_pkg::in_item_t  wdata,
	output logic               empty,
	input  logic               pop,
	output upd_pkg::out_item_t rdata
);

	// The front end decides, for each incoming byte, what it turns into (nothing, one
	// byte, two bytes or an end marker) and records that as a command. Bytes that give
	// no result, such as a percent sign or a first hex digit, leave no command.
	logic          accept;
	logic          cmd_push;
	upd_pkg::cmd_t front_cmd;

	// The queue lets the front end keep taking a transaction per cycle, until it fills, while the
	// back end gives out both results of a command that carries two, or while the consumer stalls.
	logic          q_full;
	logic          q_avail;
	logic          q_take;
	upd_pkg::cmd_t q_cmd;

	assign full   = q_full;
	assign accept = push && !q_full;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (wdata),
		.cmd_push (cmd_push),
		.cmd      (front_cmd)
	);

	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cmd_push),
		.wr_cmd    (front_cmd),
		.full      (q_full),
		.rd_en     (q_take),
		.not_empty (q_avail),
		.rd_cmd    (q_cmd)
	);

	// The back end holds the result on offer in a register, so an output transaction that
	// waits on pop never blocks the front end directly; only a full queue does.
	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (q_avail),
		.cmd       (q_cmd),
		.cmd_take  (q_take),
		.pop       (pop),
		.empty     (empty),
		.rdata     (rdata)
	);

endmodule
